// ===== rtl/papf_pkg.sv =====
package papf_pkg;

  // configuration register widths
  localparam int unsigned ProtoW    = 9;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned RangeW    = 32;
  localparam int unsigned PortW     = 16;
  localparam int unsigned MaxRanges = 4;

  // protocol_match value that accepts every protocol
  localparam logic [ProtoW-1:0] ProtoAny = 9'd256;

  // address octet codes
  localparam logic [7:0] V4Private10  = 8'd10;
  localparam logic [7:0] V4Private172 = 8'd172;
  localparam logic [7:0] V4Private192 = 8'd192;
  localparam logic [7:0] V4Private168 = 8'd168;
  localparam logic [7:0] V4Loopback   = 8'd127;
  localparam logic [7:0] V4LinkA      = 8'd169;
  localparam logic [7:0] V4LinkB      = 8'd254;
  localparam logic [7:0] V4Multicast  = 8'd224;
  localparam logic [7:0] V6UlaMask    = 8'hFE;
  localparam logic [7:0] V6Ula        = 8'hFC;
  localparam logic [7:0] V6Multicast  = 8'hFF;
  localparam logic [7:0] V6LinkLocal  = 8'hFE;
  localparam logic [7:0] V6LinkMask   = 8'hC0;
  localparam logic [7:0] V6LinkBits   = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIncomingOnly  = 3'd0,
    CfgProtocolMatch = 3'd1,
    CfgHideNoise     = 3'd2,
    CfgPublicOnly    = 3'd3,
    CfgInvertRanges  = 3'd4,
    CfgRangeCount    = 3'd5,
    CfgRangesFirst   = 3'd6,
    CfgRangesSecond  = 3'd7
  } cfg_idx_e;

  // scalar filter settings
  typedef struct packed {
    logic              inbound_only;
    logic [ProtoW-1:0] protocol_match;
    logic              drop_noise;
    logic              require_public;
    logic              invert_ranges;
    logic [CountW-1:0] range_count;
  } cfg_t;

  // address class
  typedef struct packed {
    logic noise;
    logic public_addr;
  } addr_class_t;

endpackage

// ===== rtl/packet_address_port_filter.sv =====
// packet address and port filter
//
// input channel: a packet event is transferred at a rising edge with start high
// and busy low. busy is always low, so one packet can enter every cycle.
// result channel: done_o is high for exactly one cycle with allowed_o,
// is_noise_o and is_public_o; the result is transferred at the edge ending
// that cycle. the receiver cannot stall, results are never held.
// order: a packet passes the input register, then the result register,
// which drives done_o and the result outputs.
// throughput: 1 packet per cycle, set by the single register-to-register pass
// of classify and filter logic.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at the
// clock edge; the user writes only with no packet in flight; not enforced here.
// reset: rst_ni low clears both pipeline valid flags and returns the settings
// to defaults (protocol_match accepts any protocol, filters off, no ranges).
// RANGES sets how many port range compare lanes and range registers exist.
module packet_address_port_filter #(
  parameter int unsigned RANGES = papf_pkg::MaxRanges
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // packet input
  input  logic                           start,
  output logic                           busy,
  input  logic                           direction_i,
  input  logic [7:0]                     packet_protocol_i,
  input  logic                           address_valid_i,
  input  logic                           is_ipv6_i,
  input  logic [63:0]                    address_high_i,
  input  logic [63:0]                    address_low_i,
  input  logic [papf_pkg::PortW-1:0]     remote_port_number_i,
  // result output
  output logic                           done_o,
  output logic                           allowed_o,
  output logic                           is_noise_o,
  output logic                           is_public_o,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [papf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [papf_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // settings
  papf_pkg::cfg_t                      cfg_q;
  logic [RANGES*papf_pkg::RangeW-1:0]  ranges_q;

  // input register
  logic                                in_vld_q;
  logic                                dir_q;
  logic [7:0]                          proto_q;
  logic                                addr_vld_q;
  logic                                v6_q;
  logic [63:0]                         hi_q;
  logic [63:0]                         lo_q;
  logic [papf_pkg::PortW-1:0]          port_q;

  // result register
  logic                                done_q;
  logic                                allowed_q, noise_q, public_q;

  papf_pkg::addr_class_t               addr_class;
  logic                                allowed_d;

  // no iteration, so the block never refuses a packet
  assign busy = 1'b0;

  // scalar settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inbound_only   <= 1'b0;
      cfg_q.protocol_match <= papf_pkg::ProtoAny;
      cfg_q.drop_noise     <= 1'b0;
      cfg_q.require_public <= 1'b0;
      cfg_q.invert_ranges  <= 1'b0;
      cfg_q.range_count    <= '0;
    end else if (cfg_we_i) begin
      case (papf_pkg::cfg_idx_e'(cfg_index_i))
        papf_pkg::CfgIncomingOnly:  cfg_q.inbound_only   <= cfg_wdata_i[0];
        papf_pkg::CfgProtocolMatch: cfg_q.protocol_match <= cfg_wdata_i[papf_pkg::ProtoW-1:0];
        papf_pkg::CfgHideNoise:     cfg_q.drop_noise     <= cfg_wdata_i[0];
        papf_pkg::CfgPublicOnly:    cfg_q.require_public <= cfg_wdata_i[0];
        papf_pkg::CfgInvertRanges:  cfg_q.invert_ranges  <= cfg_wdata_i[0];
        papf_pkg::CfgRangeCount:    cfg_q.range_count    <= cfg_wdata_i[papf_pkg::CountW-1:0];
        default: begin
          // range pairs are handled below
        end
      endcase
    end
  end

  // range words: even ranges sit in the low half of a pair, odd in the high half
  for (genvar i = 0; i < RANGES; i++) begin : g_range
    localparam int unsigned Half = i % 2;
    localparam papf_pkg::cfg_idx_e PairIdx =
      (i < 2) ? papf_pkg::CfgRangesFirst : papf_pkg::CfgRangesSecond;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ranges_q[i*papf_pkg::RangeW +: papf_pkg::RangeW] <= '0;
      end else if (cfg_we_i && cfg_index_i == PairIdx) begin
        ranges_q[i*papf_pkg::RangeW +: papf_pkg::RangeW] <=
          cfg_wdata_i[Half*papf_pkg::RangeW +: papf_pkg::RangeW];
      end
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  // input stage payload, captured on each transfer
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      dir_q      <= direction_i;
      proto_q    <= packet_protocol_i;
      addr_vld_q <= address_valid_i;
      v6_q       <= is_ipv6_i;
      hi_q       <= address_high_i;
      lo_q       <= address_low_i;
      port_q     <= remote_port_number_i;
    end
  end

  // address classification
  papf_classify u_classify (
    .address_valid_i (addr_vld_q),
    .is_ipv6_i       (v6_q),
    .address_high_i  (hi_q),
    .address_low_i   (lo_q),
    .class_o         (addr_class)
  );

  // direction, protocol, address class and port range filters
  papf_match #(
    .RANGES (RANGES)
  ) u_match (
    .cfg_i             (cfg_q),
    .ranges_i          (ranges_q),
    .direction_i       (dir_q),
    .packet_protocol_i (proto_q),
    .port_i            (port_q),
    .class_i           (addr_class),
    .allowed_o         (allowed_d)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      allowed_q <= allowed_d;
      noise_q   <= addr_class.noise;
      public_q  <= addr_class.public_addr;
    end
  end

  assign done_o      = done_q;
  assign allowed_o   = allowed_q;
  assign is_noise_o  = noise_q;
  assign is_public_o = public_q;

  // every accepted packet reaches the input stage on the next edge
  a_in_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> in_vld_q)
    else $error("accepted packet missing from input stage");

  // every input stage packet produces a result strobe
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o)
    else $error("input stage packet produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q))
    else $error("result strobe without a packet");

  // a public address is never noise
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_noise_o && is_public_o))
    else $error("address flagged both noise and public");

  // noise hiding must block the packet
  a_hide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg_q.drop_noise && is_noise_o) |-> !allowed_o)
    else $error("noise packet passed with noise hiding on");

endmodule

// ===== rtl/papf_classify.sv =====
module papf_classify (
  input  logic                 address_valid_i,
  input  logic                 is_ipv6_i,
  input  logic [63:0]          address_high_i,
  input  logic [63:0]          address_low_i,
  output papf_pkg::addr_class_t class_o
);

  logic [31:0] v4;
  logic [7:0]  a4, b4, b0;
  logic        v4_priv, v4_noise, v6_priv, v6_noise;

  assign v4 = address_low_i[31:0];
  assign a4 = v4[31:24];
  assign b4 = v4[23:16];
  assign b0 = address_high_i[63:56];

  assign v4_priv = (a4 == papf_pkg::V4Private10)
                || (a4 == papf_pkg::V4Private172 && b4[7:4] == 4'd1)
                || (a4 == papf_pkg::V4Private192 && b4 == papf_pkg::V4Private168);

  assign v4_noise = (v4 == 32'd0) || (&v4)
                 || (a4 == papf_pkg::V4Loopback)
                 || (a4 == papf_pkg::V4LinkA && b4 == papf_pkg::V4LinkB)
                 || (a4 >= papf_pkg::V4Multicast);

  assign v6_priv = (b0 & papf_pkg::V6UlaMask) == papf_pkg::V6Ula;

  // unspecified and loopback, multicast, fe80::/10
  assign v6_noise = (address_high_i == 64'd0 && address_low_i[63:1] == 63'd0)
                 || (b0 == papf_pkg::V6Multicast)
                 || (b0 == papf_pkg::V6LinkLocal
                     && (address_high_i[55:48] & papf_pkg::V6LinkMask)
                        == papf_pkg::V6LinkBits);

  always_comb begin
    if (!address_valid_i) begin
      class_o.noise       = 1'b1;
      class_o.public_addr = 1'b0;
    end else if (is_ipv6_i) begin
      class_o.noise       = v6_noise;
      class_o.public_addr = !v6_priv && !v6_noise;
    end else begin
      class_o.noise       = v4_noise;
      class_o.public_addr = !v4_priv && !v4_noise;
    end
  end

endmodule

// ===== rtl/papf_match.sv =====
module papf_match #(
  parameter int unsigned RANGES = papf_pkg::MaxRanges
) (
  input  papf_pkg::cfg_t                       cfg_i,
  input  logic [RANGES*papf_pkg::RangeW-1:0]   ranges_i,
  input  logic                                 direction_i,
  input  logic [7:0]                           packet_protocol_i,
  input  logic [papf_pkg::PortW-1:0]           port_i,
  input  papf_pkg::addr_class_t                class_i,
  output logic                                 allowed_o
);

  localparam logic [papf_pkg::CountW-1:0] RangesC = papf_pkg::CountW'(RANGES);

  logic [papf_pkg::CountW-1:0] count_eff;
  logic [RANGES-1:0]           lane_hit;
  logic                        matched;
  logic                        proto_ok, port_ok;

  assign count_eff = (cfg_i.range_count > RangesC) ? RangesC : cfg_i.range_count;

  // one compare lane per range
  for (genvar i = 0; i < RANGES; i++) begin : g_lane
    logic [papf_pkg::PortW-1:0] r_start, r_end;
    assign r_start = ranges_i[i*papf_pkg::RangeW + papf_pkg::PortW +: papf_pkg::PortW];
    assign r_end   = ranges_i[i*papf_pkg::RangeW +: papf_pkg::PortW];
    assign lane_hit[i] = (papf_pkg::CountW'(i) < count_eff)
                      && (port_i >= r_start) && (port_i <= r_end);
  end

  assign matched  = |lane_hit;
  assign port_ok  = (cfg_i.range_count == '0) || (cfg_i.invert_ranges ? !matched : matched);
  assign proto_ok = (cfg_i.protocol_match == papf_pkg::ProtoAny)
                 || (cfg_i.protocol_match == {1'b0, packet_protocol_i});

  assign allowed_o = !(cfg_i.inbound_only && direction_i)
                  && proto_ok
                  && !(cfg_i.drop_noise && class_i.noise)
                  && !(cfg_i.require_public && !class_i.public_addr)
                  && port_ok;

endmodule

// ===== bench/packet_address_port_filter_tb.sv =====
`timescale 1ns / 1ps

module packet_address_port_filter_tb;

  // one packet event as driven on the input ports
  typedef struct packed {
    logic        direction;
    logic [7:0]  packet_protocol;
    logic        address_valid;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] remote_port_number;
  } packet_t;

  // one verdict as seen on the result ports
  typedef struct packed {
    logic allowed;
    logic is_noise;
    logic is_public;
  } verdict_t;

  // keeps a copy of the filter settings, predicts the verdict of every
  // accepted packet and checks the verdicts in order
  class verdict_checker;
    papf_pkg::cfg_t cfg;
    logic [63:0]    ranges_first;
    logic [63:0]    ranges_second;
    verdict_t       expected_verdicts[$];
    int             errors;

    function new();
      cfg = '0;
      cfg.protocol_match = papf_pkg::ProtoAny;
      ranges_first = '0;
      ranges_second = '0;
      errors = 0;
    endfunction

    function void set_register(papf_pkg::cfg_idx_e idx, logic [63:0] value);
      case (idx)
        papf_pkg::CfgIncomingOnly:  cfg.inbound_only   = value[0];
        papf_pkg::CfgProtocolMatch: cfg.protocol_match = value[papf_pkg::ProtoW-1:0];
        papf_pkg::CfgHideNoise:     cfg.drop_noise     = value[0];
        papf_pkg::CfgPublicOnly:    cfg.require_public = value[0];
        papf_pkg::CfgInvertRanges:  cfg.invert_ranges  = value[0];
        papf_pkg::CfgRangeCount:    cfg.range_count    = value[papf_pkg::CountW-1:0];
        papf_pkg::CfgRangesFirst:   ranges_first       = value;
        papf_pkg::CfgRangesSecond:  ranges_second      = value;
        default: ;
      endcase
    endfunction

    // range word i: start in the high half, inclusive last port in the low half
    function logic [31:0] range_word(int i);
      logic [63:0] pair;
      pair = (i < 2) ? ranges_first : ranges_second;
      return (i % 2 == 1) ? pair[63:32] : pair[31:0];
    endfunction

    function verdict_t classify_and_filter(packet_t p);
      verdict_t    v;
      logic [31:0] host;
      logic [7:0]  a, b;
      logic        priv, hit;
      logic [31:0] w;
      int          lanes;
      if (!p.address_valid) begin
        v.is_noise = 1'b1;
        v.is_public = 1'b0;
      end else if (p.is_ipv6) begin
        a = p.address_high[63:56];
        b = p.address_high[55:48];
        v.is_noise = (p.address_high == '0
                      && (p.address_low == 64'd0 || p.address_low == 64'd1))
                     || a == papf_pkg::V6Multicast
                     || (a == papf_pkg::V6LinkLocal
                         && (b & papf_pkg::V6LinkMask) == papf_pkg::V6LinkBits);
        priv = (a & papf_pkg::V6UlaMask) == papf_pkg::V6Ula;
        v.is_public = !priv && !v.is_noise;
      end else begin
        // only the low 32 bits carry an ipv4 address
        host = p.address_low[31:0];
        a = host[31:24];
        b = host[23:16];
        v.is_noise = host == 32'd0 || host == 32'hFFFF_FFFF || a == papf_pkg::V4Loopback
                     || (a == papf_pkg::V4LinkA && b == papf_pkg::V4LinkB)
                     || a >= papf_pkg::V4Multicast;
        priv = a == papf_pkg::V4Private10
               || (a == papf_pkg::V4Private172 && b >= 8'd16 && b <= 8'd31)
               || (a == papf_pkg::V4Private192 && b == papf_pkg::V4Private168);
        v.is_public = !priv && !v.is_noise;
      end

      v.allowed = 1'b1;
      if (cfg.inbound_only && p.direction) v.allowed = 1'b0;
      if (cfg.protocol_match != papf_pkg::ProtoAny
          && {1'b0, p.packet_protocol} != cfg.protocol_match)
        v.allowed = 1'b0;
      if (cfg.drop_noise && v.is_noise) v.allowed = 1'b0;
      if (cfg.require_public && !v.is_public) v.allowed = 1'b0;

      // port ranges, count saturated to the number of lanes
      if (cfg.range_count != '0) begin
        lanes = (cfg.range_count > papf_pkg::MaxRanges) ? int'(papf_pkg::MaxRanges)
                                                         : int'(cfg.range_count);
        hit = 1'b0;
        for (int i = 0; i < lanes; i++) begin
          w = range_word(i);
          if (p.remote_port_number >= w[31:16] && p.remote_port_number <= w[15:0]) hit = 1'b1;
        end
        if (cfg.invert_ranges ? hit : !hit) v.allowed = 1'b0;
      end
      return v;
    endfunction

    function void note_packet(packet_t p);
      expected_verdicts.push_back(classify_and_filter(p));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict with no packet outstanding");
      end else begin
        want = expected_verdicts.pop_front();
        if (got.allowed !== want.allowed)
          report_mismatch($sformatf("allowed got %b want %b", got.allowed, want.allowed));
        if (got.is_noise !== want.is_noise)
          report_mismatch($sformatf("is_noise got %b want %b", got.is_noise, want.is_noise));
        if (got.is_public !== want.is_public)
          report_mismatch($sformatf("is_public got %b want %b", got.is_public, want.is_public));
      end
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction

    task drop_leftovers();
      if (expected_verdicts.size() != 0) begin
        report_mismatch($sformatf("%0d verdicts never came", expected_verdicts.size()));
        expected_verdicts.delete();
      end
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  packet_t        pkt_q = '0;
  logic           done_o;
  logic           allowed_o;
  logic           is_noise_o;
  logic           is_public_o;
  logic           cfg_we_i = 1'b0;
  logic [papf_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [papf_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  verdict_checker board = new();

  always #6 clk_i = ~clk_i;

  packet_address_port_filter dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .direction_i          (pkt_q.direction),
    .packet_protocol_i    (pkt_q.packet_protocol),
    .address_valid_i      (pkt_q.address_valid),
    .is_ipv6_i            (pkt_q.is_ipv6),
    .address_high_i       (pkt_q.address_high),
    .address_low_i        (pkt_q.address_low),
    .remote_port_number_i (pkt_q.remote_port_number),
    .done_o               (done_o),
    .allowed_o            (allowed_o),
    .is_noise_o           (is_noise_o),
    .is_public_o          (is_public_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  // monitor: everything sampled at the edge, so it sees pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_verdict({allowed_o, is_noise_o, is_public_o});
      if (start && !busy) board.note_packet(pkt_q);
      if (cfg_we_i) board.set_register(papf_pkg::cfg_idx_e'(cfg_index_i), cfg_wdata_i);
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("[packet_address_port_filter] ERROR");
    $finish;
  end

  // one register write; the caller lowers the write enable after its last write
  task write_reg(papf_pkg::cfg_idx_e idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // a port range: mostly start below end, sometimes random and possibly empty (start above end)
  function logic [31:0] random_range_word();
    logic [15:0] first_port, last_port;
    int          span;
    first_port = 16'($urandom_range(65535));
    if ($urandom_range(4) == 0) begin
      last_port = 16'($urandom_range(65535));
    end else begin
      span = first_port + $urandom_range(3000);
      last_port = (span > 65535) ? 16'hFFFF : span[15:0];
    end
    return {first_port, last_port};
  endfunction

  function logic [63:0] random_setting(papf_pkg::cfg_idx_e idx);
    logic [63:0] v;
    logic [63:0] junk;
    int          w;
    junk = {$urandom, $urandom};
    w = 1;
    case (idx)
      papf_pkg::CfgIncomingOnly, papf_pkg::CfgHideNoise, papf_pkg::CfgInvertRanges:
        v = 64'($urandom_range(1));
      papf_pkg::CfgPublicOnly: v = 64'($urandom_range(3) == 0);
      papf_pkg::CfgProtocolMatch: begin
        w = int'(papf_pkg::ProtoW);
        case ($urandom_range(3))
          0, 1:    v = 64'(papf_pkg::ProtoAny);
          2:       v = 64'($urandom_range(255));
          default: v = 64'($urandom_range(511, 257));
        endcase
      end
      papf_pkg::CfgRangeCount: begin
        w = int'(papf_pkg::CountW);
        v = 64'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 1));
      end
      default: v = {random_range_word(), random_range_word()};
    endcase
    // bits above the register width should have no effect
    if (idx != papf_pkg::CfgRangesFirst && idx != papf_pkg::CfgRangesSecond
        && $urandom_range(3) == 0)
      v = v | (junk << w);
    return v;
  endfunction

  // mode 0: everything zero, mode 1: everything ones, otherwise random
  task configure(int mode);
    logic [63:0] value;
    for (int i = 0; i < 8; i++) begin
      if (mode == 0) value = '0;
      else if (mode == 1) value = '1;
      else value = random_setting(papf_pkg::cfg_idx_e'(i));
      write_reg(papf_pkg::cfg_idx_e'(i), value);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drive one packet and hold it until the transfer happens
  task send_packet(packet_t p);
    logic taken;
    start <= 1'b1;
    pkt_q <= p;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // wait for all outstanding verdicts, then report any that never came
  task wait_idle();
    int guard;
    guard = 0;
    while (board.pending() != 0 && guard < 64) begin
      @(posedge clk_i);
      guard++;
    end
    board.drop_leftovers();
    repeat (4) @(posedge clk_i);
  endtask

  // address mix biased toward the class boundaries
  task make_address(output packet_t p);
    logic [7:0] v4_lead [10];
    logic [7:0] v4_second [7];
    logic [7:0] v6_lead [8];
    logic [7:0] v6_second [6];
    int         kind;
    v4_lead   = '{8'd0, papf_pkg::V4Private10, papf_pkg::V4Loopback, papf_pkg::V4LinkA,
                  papf_pkg::V4Private172, papf_pkg::V4Private192, 8'd223,
                  papf_pkg::V4Multicast, 8'd255, 8'd8};
    v4_second = '{8'd15, 8'd16, 8'd31, 8'd32, papf_pkg::V4Private168, papf_pkg::V4LinkB,
                  8'd253};
    v6_lead   = '{8'hFC, 8'hFD, 8'hFE, papf_pkg::V6Multicast, 8'h00, 8'h20, 8'hFB, 8'hFA};
    v6_second = '{8'h80, 8'hBF, 8'hC0, 8'h7F, 8'h00, 8'hFF};
    p.address_high = {$urandom, $urandom};
    p.address_low = {$urandom, $urandom};
    p.address_valid = ($urandom_range(9) != 0);
    p.is_ipv6 = 1'($urandom_range(1));
    if (!p.is_ipv6) begin
      kind = $urandom_range(11);
      if (kind == 0) p.address_low[31:0] = '0;
      else if (kind == 1) p.address_low[31:0] = '1;
      else if (kind <= 9)
        p.address_low[31:16] = {v4_lead[$urandom_range(9)], v4_second[$urandom_range(6)]};
    end else begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        p.address_high = '0;
        p.address_low = '0;
      end else if (kind <= 2) begin
        // around the loopback address
        p.address_high = '0;
        p.address_low = 64'($urandom_range(3));
      end else if (kind <= 7) begin
        p.address_high[63:48] = {v6_lead[$urandom_range(7)], v6_second[$urandom_range(5)]};
      end
    end
  endtask

  task make_packet(output packet_t p);
    logic [31:0] w;
    int          pick;
    make_address(p);
    p.direction = 1'($urandom_range(1));
    // match the required protocol half the time so allowed verdicts occur
    if (board.cfg.protocol_match < papf_pkg::ProtoAny && $urandom_range(1) == 1)
      p.packet_protocol = board.cfg.protocol_match[7:0];
    else
      p.packet_protocol = 8'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 5) begin
      // on or right next to a range bound
      w = board.range_word(int'($urandom_range(3)));
      p.remote_port_number = ($urandom_range(1) ? w[31:16] : w[15:0])
                             + 16'($urandom_range(2)) - 16'd1;
    end else if (pick == 5) begin
      p.remote_port_number = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else begin
      p.remote_port_number = 16'($urandom_range(65535));
    end
  endtask

  // one directed address with random everything else
  task send_address(logic valid, logic v6, logic [63:0] hi, logic [63:0] lo);
    packet_t p;
    p.direction = 1'($urandom_range(1));
    p.packet_protocol = 8'($urandom_range(255));
    p.address_valid = valid;
    p.is_ipv6 = v6;
    p.address_high = hi;
    p.address_low = lo;
    p.remote_port_number = 16'($urandom_range(65535));
    send_packet(p);
  endtask

  // a burst of random packets; each cycle the sender idles with idle_pct percent
  task run_group(int count, int idle_pct);
    packet_t p;
    for (int i = 0; i < count; i++) begin
      make_packet(p);
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      send_packet(p);
    end
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] junk;
    int          idle_pct;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed addresses under the reset settings, upper bits junk for ipv4
    junk = {$urandom, $urandom};
    send_address(1'b1, 1'b0, junk, {junk[31:0], 32'h0000_0000});
    send_address(1'b1, 1'b0, junk, {junk[31:0], 32'hFFFF_FFFF});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'h7F00_0001});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hA9FE_0101});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hA9FD_0101});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hE000_0001});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hDFFF_FFFF});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'h0A01_0203});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hAC0F_0001});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hAC10_0001});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hAC1F_FFFF});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hAC20_0000});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'hC0A8_0101});
    send_address(1'b1, 1'b0, junk, {junk[63:32], 32'h0808_0808});
    send_address(1'b1, 1'b1, 64'd0, 64'd0);
    send_address(1'b1, 1'b1, 64'd0, 64'd1);
    send_address(1'b1, 1'b1, 64'd0, 64'd2);
    send_address(1'b1, 1'b1, 64'hFF02_0000_0000_0000, 64'd1);
    send_address(1'b1, 1'b1, 64'hFE80_0000_0000_0000, 64'd1);
    send_address(1'b1, 1'b1, 64'hFEBF_FFFF_FFFF_FFFF, '1);
    send_address(1'b1, 1'b1, 64'hFEC0_0000_0000_0000, 64'd1);
    send_address(1'b1, 1'b1, 64'hFC00_0000_0000_0000, 64'd1);
    send_address(1'b1, 1'b1, 64'hFDFF_FFFF_FFFF_FFFF, '1);
    send_address(1'b1, 1'b1, 64'h2001_0DB8_0000_0000, 64'd1);
    send_address(1'b0, 1'b0, junk, {junk[63:32], 32'h0808_0808});
    start <= 1'b0;
    @(posedge clk_i);
    wait_idle();

    // random part: first two groups at the setting extremes, then random
    // settings; sender idles 27 percent, then 45 percent, then never
    for (int g = 0; g < 16; g++) begin
      configure((g < 2) ? g : 2);
      idle_pct = (g < 6) ? 27 : (g < 11) ? 45 : 0;
      run_group(50, idle_pct);
      // every group ends with the sender holding off until all verdicts came
      wait_idle();
    end

    if (board.errors == 0) begin
      $display("[packet_address_port_filter] OK");
    end else begin
      $display("[packet_address_port_filter] ERROR");
    end
    $finish;
  end

endmodule
